// ===== rtl/core/i2r_pkg.sv =====
// ----------------------------------------------------------------------------
// i2r_pkg
// Shared constants, term tables and control types for the integer to Roman
// numeral converter.
// ----------------------------------------------------------------------------
`default_nettype none

package i2r_pkg;

	localparam int unsigned VALUE_W  = 12;
	localparam int unsigned LETTER_W = 8;
	localparam int unsigned TERMS    = 13;
	localparam int unsigned TERM_W   = $clog2(TERMS);

	localparam logic [VALUE_W-1:0] MAX_VALUE = VALUE_W'(3999);

	// ASCII codes of the Roman letters
	localparam logic [LETTER_W-1:0] LTR_NONE = 8'h00;
	localparam logic [LETTER_W-1:0] LTR_I    = 8'h49;
	localparam logic [LETTER_W-1:0] LTR_V    = 8'h56;
	localparam logic [LETTER_W-1:0] LTR_X    = 8'h58;
	localparam logic [LETTER_W-1:0] LTR_L    = 8'h4C;
	localparam logic [LETTER_W-1:0] LTR_C    = 8'h43;
	localparam logic [LETTER_W-1:0] LTR_D    = 8'h44;
	localparam logic [LETTER_W-1:0] LTR_M    = 8'h4D;

	// Terms in descending weight; a term has one or two letters
	localparam logic [VALUE_W-1:0] TERM_WEIGHT [TERMS] = '{
		12'd1000, 12'd900, 12'd500, 12'd400, 12'd100, 12'd90, 12'd50,
		12'd40, 12'd10, 12'd9, 12'd5, 12'd4, 12'd1
	};
	localparam logic [LETTER_W-1:0] TERM_FIRST [TERMS] = '{
		LTR_M, LTR_C, LTR_D, LTR_C, LTR_C, LTR_X, LTR_L,
		LTR_X, LTR_X, LTR_I, LTR_V, LTR_I, LTR_I
	};
	localparam logic [LETTER_W-1:0] TERM_SECOND [TERMS] = '{
		LTR_NONE, LTR_M, LTR_NONE, LTR_D, LTR_NONE, LTR_C, LTR_NONE,
		LTR_L, LTR_NONE, LTR_X, LTR_NONE, LTR_V, LTR_NONE
	};

	// Controller to datapath
	typedef struct packed {
		logic load;   // take a new value
		logic step;   // produce the next letter into the output register
	} i2r_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic last;   // the letter produced by this step closes the run
	} i2r_sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/i2r_num_if.sv =====
// ----------------------------------------------------------------------------
// i2r_num_if
// Input channel: one unsigned value per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface i2r_num_if
	import i2r_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [VALUE_W-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/i2r_roman_if.sv =====
// ----------------------------------------------------------------------------
// i2r_roman_if
// Output channel: one Roman letter per beat with last and error marks.
// ----------------------------------------------------------------------------
`default_nettype none

interface i2r_roman_if
	import i2r_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [LETTER_W-1:0] letter;
	logic                last;
	logic                error;

	modport source (output valid, output letter, output last, output error, input ready);
	modport sink   (input valid, input letter, input last, input error, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/integer_to_roman.sv =====
// ----------------------------------------------------------------------------
// integer_to_roman
// Converts an unsigned 12-bit value to its standard Roman numeral and sends
// it as a run of ASCII letters, most significant first, last letter marked.
// ----------------------------------------------------------------------------
//
//  channel | dir | payload               | beat
//  --------+-----+-----------------------+---------------------------------
//  num     | in  | value[11:0]           | one value to convert
//  roman   | out | letter[7:0],last,error| one letter; error beat for 0/>3999
//
// An item is loaded, then sent one letter per cycle while the output
// register is not stalled (3888 needs 15 letters). A value of 0 or above
// 3999 gives a single error beat. Downstream stalls hold the output
// register and pause letter generation. A new value is taken as soon as
// the last letter of the previous run sits in the output register, even
// if it has not been taken yet. Reset clears the controller and the
// output valid; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_to_roman
	import i2r_pkg::*;
(
	input wire logic   clk,
	input wire logic   arst_n,
	i2r_num_if.sink    num,
	i2r_roman_if.source roman
);

	i2r_cmd_t cmd;
	i2r_sts_t sts;

	// Sequencing and handshakes
	i2r_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.num_valid   (num.valid),
		.num_ready   (num.ready),
		.roman_valid (roman.valid),
		.roman_ready (roman.ready),
		.cmd         (cmd),
		.sts         (sts)
	);

	// Remaining value, term choice and output payload
	i2r_dp u_dp (
		.clk    (clk),
		.cmd    (cmd),
		.sts    (sts),
		.value  (num.value),
		.letter (roman.letter),
		.last   (roman.last),
		.error  (roman.error)
	);

endmodule

`default_nettype wire

// ===== rtl/core/i2r_dp.sv =====
// ----------------------------------------------------------------------------
// i2r_dp
// Datapath: remaining value, pending second letter of a subtractive pair,
// term selection and the output payload register.
// ----------------------------------------------------------------------------
`default_nettype none

module i2r_dp
	import i2r_pkg::*;
(
	input  wire logic                clk,
	input  wire i2r_cmd_t            cmd,
	output      i2r_sts_t            sts,
	input  wire logic [VALUE_W-1:0]  value,
	output      logic [LETTER_W-1:0] letter,
	output      logic                last,
	output      logic                error
);

	logic [VALUE_W-1:0]  rest_q;
	logic                err_q;
	logic                half_q;   // second letter of a pair is due
	logic [TERM_W-1:0]   term_q;

	logic [LETTER_W-1:0] letter_q;
	logic                last_q;
	logic                error_q;

	logic [TERM_W-1:0]   pick;
	logic [TERM_W-1:0]   cur;
	logic [VALUE_W-1:0]  weight;
	logic                pair_first;
	logic [LETTER_W-1:0] nxt_letter;
	logic                nxt_last;

	// Largest term that fits into what is left
	always_comb begin
		pick = TERM_W'(TERMS - 1);
		for (int t = TERMS - 1; t >= 0; t--) begin
			if (rest_q >= TERM_WEIGHT[t]) begin
				pick = TERM_W'(t);
			end
		end
	end

	always_comb begin
		cur        = half_q ? term_q : pick;
		weight     = TERM_WEIGHT[cur];
		pair_first = !half_q && (TERM_SECOND[pick] != LTR_NONE);
		if (err_q) begin
			nxt_letter = LTR_NONE;
			nxt_last   = 1'b1;
		end else if (half_q) begin
			nxt_letter = TERM_SECOND[term_q];
			nxt_last   = (rest_q == weight);
		end else begin
			nxt_letter = TERM_FIRST[pick];
			nxt_last   = !pair_first && (rest_q == weight);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rest_q <= value;
			err_q  <= (value == '0) || (value > MAX_VALUE);
			half_q <= 1'b0;
		end else if (cmd.step) begin
			if (pair_first) begin
				half_q <= 1'b1;
				term_q <= pick;
			end else begin
				half_q <= 1'b0;
				rest_q <= rest_q - weight;
			end
		end
	end

	// Output payload register
	always_ff @(posedge clk) begin
		if (cmd.step) begin
			letter_q <= nxt_letter;
			last_q   <= nxt_last;
			error_q  <= err_q;
		end
	end

	assign sts.last = nxt_last;
	assign letter   = letter_q;
	assign last     = last_q;
	assign error    = error_q;

endmodule

`default_nettype wire

// ===== rtl/core/i2r_ctrl.sv =====
// ----------------------------------------------------------------------------
// i2r_ctrl
// Controller: accepts a value, then steps the datapath once per letter while
// the output register is free; owns both handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module i2r_ctrl
	import i2r_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     num_valid,
	output      logic     num_ready,
	output      logic     roman_valid,
	input  wire logic     roman_ready,
	output      i2r_cmd_t cmd,
	input  wire i2r_sts_t sts
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EMIT = 2'b10
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || roman_ready;
	assign num_ready = (state_q == ST_IDLE);
	assign cmd.load  = num_valid && num_ready;
	assign cmd.step  = (state_q == ST_EMIT) && slot_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.step) begin
				out_valid_q <= 1'b1;
			end else if (roman_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd.load) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (cmd.step && sts.last) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign roman_valid = out_valid_q;

endmodule

`default_nettype wire

// ===== rtl/core/i2r_checker.sv =====
// ----------------------------------------------------------------------------
// i2r_checker
// Port-level checks on the converter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module i2r_checker
	import i2r_pkg::*;
(
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                num_valid,
	input wire logic                num_ready,
	input wire logic                roman_valid,
	input wire logic                roman_ready,
	input wire logic [LETTER_W-1:0] roman_letter,
	input wire logic                roman_last,
	input wire logic                roman_error
);

	// An error beat is a single closing beat with no letter
	a_err_beat: assert property (@(posedge clk) disable iff (!arst_n)
		roman_valid && roman_error |-> roman_last && (roman_letter == LTR_NONE))
		else $error("error beat without last or with a letter");

	// A normal beat carries a Roman letter
	a_letter: assert property (@(posedge clk) disable iff (!arst_n)
		roman_valid && !roman_error |->
		(roman_letter == LTR_I) || (roman_letter == LTR_V) ||
		(roman_letter == LTR_X) || (roman_letter == LTR_L) ||
		(roman_letter == LTR_C) || (roman_letter == LTR_D) ||
		(roman_letter == LTR_M))
		else $error("beat carries a non-Roman letter");

	// A taken value drops input ready right after the handshake
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		num_valid && num_ready |=> !num_ready)
		else $error("input ready right after a value was taken");

	// Hold a stalled beat
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		roman_valid && !roman_ready |=> roman_valid && $stable(roman_letter) &&
		$stable(roman_last) && $stable(roman_error))
		else $error("stalled beat changed");

endmodule

bind integer_to_roman i2r_checker u_i2r_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.num_valid    (num.valid),
	.num_ready    (num.ready),
	.roman_valid  (roman.valid),
	.roman_ready  (roman.ready),
	.roman_letter (roman.letter),
	.roman_last   (roman.last),
	.roman_error  (roman.error)
);

`default_nettype wire
